[design/e2d_pkg.sv]
// Shared constants, command/status types and the month length table for the date converter.
`timescale 1ns / 1ps
`default_nettype none

package e2d_pkg;

  localparam int unsigned SEC_W       = 32;  // input seconds width
  localparam int unsigned DAYS_W      = 16;  // whole days since the epoch, at most 49710
  localparam int unsigned YEAR_W      = 12;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned YLEN_W      = 9;
  localparam int unsigned OUT_W       = 24;  // result fields padded to whole bytes

  // 86400 = 675 * 2^7. The seconds are shifted right by 7 and then divided by 675
  // through a multiplication by a rounded-up reciprocal scaled by 2^35. The error
  // term times the largest shifted value stays below 2^35, so the quotient is exact.
  localparam int unsigned DAY_SHIFT   = 7;
  localparam int unsigned SCALED_W    = SEC_W - DAY_SHIFT;   // 25
  localparam int unsigned RECIP_W     = 26;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned PROD_W      = SCALED_W + RECIP_W;  // 51

  localparam logic [RECIP_W-1:0] RECIP_675    = 26'd50903317;
  localparam logic [YEAR_W-1:0]  EPOCH_YEAR   = 12'd1970;
  localparam logic [6:0]         EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]         EPOCH_MOD400 = 9'd370;
  localparam logic [6:0]         LAST_MOD100  = 7'd99;
  localparam logic [8:0]         LAST_MOD400  = 9'd399;
  localparam logic [YLEN_W-1:0]  DAYS_LEAP    = 9'd366;
  localparam logic [YLEN_W-1:0]  DAYS_COMMON  = 9'd365;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new input item
    logic div_step;    // turn the captured seconds into whole days
    logic year_step;   // subtract the current year and advance
    logic month_step;  // subtract the current month and advance
    logic out_load;    // move the finished date into the output register
  } e2d_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic year_fit;    // remaining days lie inside the current year
    logic month_fit;   // remaining days lie inside the current month
  } e2d_sts_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[design/e2d_ctrl.sv]
// Controller state machine that sequences division, year walk, month walk and output.
`timescale 1ns / 1ps
`default_nettype none

module e2d_ctrl
  import e2d_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic     out_tready,
  output logic          out_tvalid,
  input  wire e2d_sts_t sts,
  output e2d_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_YEAR,
    ST_MONTH,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_YEAR;
      end
      ST_YEAR: begin
        if (sts.year_fit) begin
          state_nxt = ST_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (sts.month_fit) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[design/e2d_dp.sv]
// Datapath: reciprocal divider by 86400, year and month subtractors, output register.
`timescale 1ns / 1ps
`default_nettype none

module e2d_dp
  import e2d_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [SEC_W-1:0] in_tdata,
  input  wire e2d_cmd_t         cmd,
  output e2d_sts_t              sts,
  output logic [OUT_W-1:0]      out_tdata
);

  logic [SEC_W-1:0]   work_r, work_nxt;     // seconds, later the day count
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [6:0]         mod100_r, mod100_nxt;
  logic [8:0]         mod400_r, mod400_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [OUT_W-1:0]   out_r, out_nxt;

  logic [SCALED_W-1:0] scaled;
  logic [PROD_W-1:0]   prod;
  logic [DAYS_W-1:0]   days;
  logic                leap;
  logic [YLEN_W-1:0]   ylen;
  logic [DAY_W-1:0]    mlen;
  logic [DAY_W-1:0]    day_num;

  // Whole days: drop the factor 2^7 of 86400 by a shift, then divide by 675.
  assign scaled = work_r[SEC_W-1:DAY_SHIFT];
  assign prod   = {{RECIP_W{1'b0}}, scaled} * {{SCALED_W{1'b0}}, RECIP_675};

  assign days  = work_r[DAYS_W-1:0];
  assign leap  = (mod400_r == '0) || ((year_r[1:0] == 2'b00) && (mod100_r != '0));
  assign ylen  = leap ? DAYS_LEAP : DAYS_COMMON;
  assign mlen  = month_days(month_r, leap);
  assign day_num  = days[DAY_W-1:0] + 5'd1;

  assign sts.year_fit  = (days < {{(DAYS_W-YLEN_W){1'b0}}, ylen});
  assign sts.month_fit = (days < {{(DAYS_W-DAY_W){1'b0}}, mlen}) || (month_r == MON_DEC);

  always_comb begin
    work_nxt   = work_r;
    year_nxt   = year_r;
    mod100_nxt = mod100_r;
    mod400_nxt = mod400_r;
    month_nxt  = month_r;
    out_nxt    = out_r;
    if (cmd.load) begin
      work_nxt   = in_tdata;
      year_nxt   = EPOCH_YEAR;
      mod100_nxt = EPOCH_MOD100;
      mod400_nxt = EPOCH_MOD400;
      month_nxt  = MON_JAN;
    end
    if (cmd.div_step) begin
      work_nxt = {{(SEC_W-DAYS_W){1'b0}}, prod[RECIP_SHIFT +: DAYS_W]};
    end
    if (cmd.year_step) begin
      work_nxt   = {{(SEC_W-DAYS_W){1'b0}},
                    days - {{(DAYS_W-YLEN_W){1'b0}}, ylen}};
      year_nxt   = year_r + 12'd1;
      mod100_nxt = (mod100_r == LAST_MOD100) ? 7'd0 : mod100_r + 7'd1;
      mod400_nxt = (mod400_r == LAST_MOD400) ? 9'd0 : mod400_r + 9'd1;
    end
    if (cmd.month_step) begin
      work_nxt  = {{(SEC_W-DAYS_W){1'b0}},
                   days - {{(DAYS_W-DAY_W){1'b0}}, mlen}};
      month_nxt = month_r + 4'd1;
    end
    if (cmd.out_load) begin
      out_nxt = {3'b000, day_num, month_r, year_r};
    end
  end

  always_ff @(posedge clk) begin
    work_r   <= work_nxt;
    year_r   <= year_nxt;
    mod100_r <= mod100_nxt;
    mod400_r <= mod400_nxt;
    month_r  <= month_nxt;
    out_r    <= out_nxt;
  end

  assign out_tdata = out_r;

endmodule

`default_nettype wire

[design/epoch_seconds_to_date.sv]
// Top level of the seconds-since-epoch to calendar date converter.
// Steps: take the transfer, turn the seconds into whole days, walk the elapsed years
// and then the elapsed months off the day count, each walk ending in a fit check, and
// load the output, which waits while the previous result is still held. It converts one
// item at a time. A new input transfer is taken while the previous result still waits.
// Reset (rst_n low, synchronous) returns the controller to idle and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_date
  import e2d_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [SEC_W-1:0] in_tdata,   // [31:0] epoch_seconds
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata   // [11:0] year_out, [15:12] month_out,
                                            // [20:16] day_out, [23:21] zero
);

  // The controller steps the datapath through the conversion; the two talk only
  // through the command and status structs.
  e2d_cmd_t cmd;
  e2d_sts_t sts;

  e2d_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath divides the seconds into whole days, then walks years and months
  // off the day count and holds the finished date for the output transfer.
  e2d_dp u_dp (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

[tb/sv/epoch_date_checker.sv]
// Checker that predicts the calendar date of every input transfer and compares results.
`timescale 1ns / 1ps

module epoch_date_checker
  import e2d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [SEC_W-1:0] in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               mismatches,
  output int               dates_pending
);

  localparam int unsigned SECONDS_PER_DAY = 86400;

  // Packed from the top bit down, so the year lands in the lowest bits.
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } cal_date_t;

  cal_date_t expected_dates[$];

  initial begin
    mismatches    = 0;
    dates_pending = 0;
  end

  function automatic bit leap_year(input int unsigned yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  // Walks whole years, then whole months, off the zero-based day count.
  function automatic cal_date_t calendar_date_of(input logic [SEC_W-1:0] secs);
    int unsigned days_left;
    int unsigned yr;
    int unsigned mo;
    int unsigned span;
    cal_date_t   d;
    days_left = secs / SECONDS_PER_DAY;
    yr = EPOCH_YEAR;
    forever begin
      span = leap_year(yr) ? 366 : 365;
      if (days_left < span) break;
      days_left -= span;
      yr++;
    end
    mo = 1;
    while (mo < 12) begin
      case (mo)
        MON_APR, MON_JUN, MON_SEP, MON_NOV: span = 30;
        MON_FEB: span = leap_year(yr) ? 29 : 28;
        default: span = 31;
      endcase
      if (days_left < span) break;
      days_left -= span;
      mo++;
    end
    d.year  = yr[YEAR_W-1:0];
    d.month = mo[MONTH_W-1:0];
    d.day   = DAY_W'(days_left + 1);
    return d;
  endfunction

  always @(posedge clk) begin
    cal_date_t want;
    cal_date_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_dates.push_back(calendar_date_of(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[YEAR_W+MONTH_W+DAY_W-1:0];
        if (expected_dates.size() == 0) begin
          $error("result transfer with no date expected: %0d-%0d-%0d",
                 got.year, got.month, got.day);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          if (got.year !== want.year) begin
            $error("year_out: expected %0d, actual %0d", want.year, got.year);
            mismatches++;
          end
          if (got.month !== want.month) begin
            $error("month_out: expected %0d, actual %0d", want.month, got.month);
            mismatches++;
          end
          if (got.day !== want.day) begin
            $error("day_out: expected %0d, actual %0d", want.day, got.day);
            mismatches++;
          end
        end
      end
      dates_pending <= expected_dates.size();
    end
  end

endmodule

[tb/sv/epoch_seconds_to_date_tb.sv]
// Testbench top for the epoch seconds to calendar date converter: stimulus and verdict.
`timescale 1ns / 1ps

module epoch_seconds_to_date_tb;
  import e2d_pkg::*;

  // The watchdog fires once STALL_LIMIT is reached with no transfer on either channel;
  // it must outlast the slowest item and the long receiver hold-off of HOLD_CYCLES.
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1750;
  localparam int QUIET_ITEMS  = 300;   // random items sent with no gaps on either side
  localparam int HOLD_AT_ITEM = 500;   // random item at which the receiver holds off
  localparam int TAIL_CYCLES  = 200;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [SEC_W-1:0] in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  int mismatches;
  int dates_pending;
  int idle_cycles = 0;

  // Shared between the sender and the receiver process.
  bit no_gaps      = 1'b0;
  bit hold_request = 1'b0;

  always #5 clk = ~clk;

  epoch_seconds_to_date u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  epoch_date_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatches    (mismatches),
    .dates_pending (dates_pending)
  );

  function automatic bit is_leap(input int unsigned yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  function automatic int unsigned month_len(input int unsigned yr, input int unsigned mo);
    case (mo)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
      MON_FEB: return is_leap(yr) ? 29 : 28;
      default: return 31;
    endcase
  endfunction

  // Seconds at midnight starting the given date; may exceed 32 bits past early 2106.
  function automatic longint unsigned seconds_at(input int unsigned yr,
                                                 input int unsigned mo,
                                                 input int unsigned dy);
    longint unsigned days;
    days = 0;
    for (int unsigned y = EPOCH_YEAR; y < yr; y++) days += is_leap(y) ? 366 : 365;
    for (int unsigned m = 1; m < mo; m++) days += month_len(yr, m);
    days += dy - 1;
    return days * 86400;
  endfunction

  // Offers one item and returns after its transfer. Random gaps keep tvalid low
  // for whole cycles; tvalid is never dropped and raised in the same step.
  task automatic send_seconds(input longint unsigned secs);
    if (!no_gaps) begin
      while ($urandom_range(99) < 36) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= secs[SEC_W-1:0];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // A random date weighted toward month and year boundaries and leap days.
  function automatic longint unsigned boundary_seconds();
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned pick;
    longint unsigned tod;
    yr   = $urandom_range(2105, EPOCH_YEAR);
    mo   = $urandom_range(12, 1);
    pick = $urandom_range(99);
    if (pick < 20) begin
      // February end of a year divisible by four, which covers the century rules.
      yr = 1972 + 4 * $urandom_range(33, 0);
      mo = MON_FEB;
      dy = month_len(yr, mo);
    end else if (pick < 55) begin
      dy = month_len(yr, mo);
    end else if (pick < 75) begin
      dy = 1;
    end else begin
      dy = $urandom_range(month_len(yr, mo), 1);
    end
    case ($urandom_range(2))
      0: tod = 0;
      1: tod = 86399;
      default: tod = $urandom_range(86399);
    endcase
    return seconds_at(yr, mo, dy) + tod;
  endfunction

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (no_gaps) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 36);
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    longint unsigned secs;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: epoch start, day edges, year and month ends, leap rules by the
    // 4, 100 and 400 rules, and the largest input.
    send_seconds(0);
    send_seconds(86399);
    send_seconds(86400);
    send_seconds(seconds_at(1970, 1, 31) + 86399);
    send_seconds(seconds_at(1970, 2, 1));
    send_seconds(seconds_at(1970, 4, 30) + 86399);
    send_seconds(seconds_at(1970, 12, 31) + 86399);
    send_seconds(seconds_at(1971, 1, 1));
    send_seconds(seconds_at(1972, 2, 29) + 86399);
    send_seconds(seconds_at(1972, 3, 1));
    send_seconds(seconds_at(1972, 12, 31));
    send_seconds(seconds_at(2000, 2, 29));
    send_seconds(seconds_at(2000, 12, 31) + 86399);
    send_seconds(seconds_at(2100, 2, 28) + 86399);
    send_seconds(seconds_at(2100, 3, 1));
    send_seconds(seconds_at(2105, 12, 31) + 86399);
    send_seconds(seconds_at(2106, 2, 7));
    send_seconds(32'h7FFF_FFFF);
    send_seconds(32'h8000_0000);
    send_seconds(32'hAAAA_AAAA);
    send_seconds(32'h5555_5555);
    send_seconds(32'hFFFF_FFFF);

    // The sender pauses until every expected date has come back.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (dates_pending != 0) @(posedge clk);

    no_gaps = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == QUIET_ITEMS) no_gaps = 1'b0;
      if (i == HOLD_AT_ITEM) hold_request = 1'b1;
      if ($urandom_range(99) < 30) begin
        secs = $urandom;
      end else begin
        secs = boundary_seconds();
        if (secs > 64'hFFFF_FFFF) secs = $urandom;
      end
      send_seconds(secs);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (dates_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && dates_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
design/e2d_pkg.sv
design/e2d_ctrl.sv
design/e2d_dp.sv
design/epoch_seconds_to_date.sv
tb/sv/epoch_date_checker.sv
tb/sv/epoch_seconds_to_date_tb.sv
